[hdl/round_robin_tick_scheduler_unit_macros.svh]
// ----------------------------------------------------------------------------
// Round-robin tick scheduler assertion macros
// Shared wrappers for concurrent checks on the scheduler ports.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_TICK_SCHEDULER_UNIT_MACROS_SVH
`define ROUND_ROBIN_TICK_SCHEDULER_UNIT_MACROS_SVH

// The consequent must hold at the same clock edge as the antecedent.
`define RRTS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rrts check failed in same-cycle property");

// The consequent must hold at the clock edge after the antecedent.
`define RRTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rrts check failed in next-cycle property");

`endif

[hdl/rrts_pkg.sv]
// ----------------------------------------------------------------------------
// Round-robin tick scheduler package
// Item and entry types, codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

  localparam int NUM_PROCS_DEF = 16;
  localparam int PADDR_W       = 3;

  localparam logic [7:0] TIME_SLICE_RST = 8'd16;

  // Register index, taken from paddr[2].
  localparam logic REG_TIME_SLICE = 1'b0;

  // Process states.
  localparam logic [2:0] PS_DEAD     = 3'd0;
  localparam logic [2:0] PS_RUNNABLE = 3'd1;
  localparam logic [2:0] PS_RUNNING  = 3'd2;
  localparam logic [2:0] PS_SLEEPING = 3'd3;

  // Request codes.
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_SLEEP = 2'd1;
  localparam logic [1:0] REQ_YIELD = 2'd2;
  localparam logic [1:0] REQ_WRITE = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  target_pid;
    logic [2:0]  new_state;
    logic        new_blocked;
    logic [15:0] sleep_ticks;
  } req_item_t;

  typedef struct packed {
    logic [3:0]  running_pid;
    logic        switched;
    logic [31:0] tick_total;
    logic        status;
  } rsp_item_t;

  typedef struct packed {
    logic [2:0]  pstate;
    logic        blocked;
    logic [15:0] sleep_cnt;
    logic [7:0]  slice_cnt;
  } entry_t;

  localparam entry_t ENTRY_DEAD  = '{pstate: PS_DEAD, blocked: 1'b0,
                                     sleep_cnt: 16'd0, slice_cnt: 8'd0};
  localparam entry_t ENTRY_IDLE0 = '{pstate: PS_RUNNING, blocked: 1'b0,
                                     sleep_cnt: 16'd0, slice_cnt: 8'd0};

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENTRY,
    S_CUR_RD,
    S_CUR_CAP,
    S_SCAN,
    S_DECIDE,
    S_SWITCH,
    S_DONE
  } ctl_state_t;

  typedef struct packed {
    logic latch_req;
    logic entry_wr;
    logic cur_rd;
    logic cur_cap;
    logic scan_start;
    logic scan_run;
    logic decide;
    logic switch_en;
    logic rsp_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       ticks_zero;
    logic       cur_ok;
    logic       scan_done;
    logic       need_switch;
  } sts_t;

endpackage

`default_nettype wire

[hdl/rrts_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_ram #(
  parameter int WIDTH = $bits(rrts_pkg::entry_t),
  parameter int DEPTH = rrts_pkg::NUM_PROCS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hdl/rrts_ctrl.sv]
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences one item: entry write, or current-entry read, sleeper scan,
// decision, optional switch, and the result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         req_valid,
  output logic              req_stall,
  output logic              rsp_valid,
  input  wire logic         rsp_stall,
  input  wire rrts_pkg::sts_t sts,
  output rrts_pkg::cmd_t    cmd
);

  rrts_pkg::ctl_state_t state;
  rrts_pkg::ctl_state_t state_next;
  logic                 rsp_valid_next;
  logic                 out_free;
  logic                 early_done;

  assign out_free   = !rsp_valid || !rsp_stall;
  // A zero-length sleep or a refused yield finishes without a tick.
  assign early_done = (sts.req_type == rrts_pkg::REQ_SLEEP && sts.ticks_zero) ||
                      (sts.req_type == rrts_pkg::REQ_YIELD && !sts.cur_ok);

  always_comb begin
    state_next = state;
    case (state)
      rrts_pkg::S_IDLE: begin
        if (req_valid) begin
          state_next = rrts_pkg::S_CUR_RD;
        end
      end
      rrts_pkg::S_ENTRY:   state_next = rrts_pkg::S_DONE;
      rrts_pkg::S_CUR_RD:  state_next = rrts_pkg::S_CUR_CAP;
      rrts_pkg::S_CUR_CAP: begin
        state_next = early_done ? rrts_pkg::S_DONE : rrts_pkg::S_SCAN;
      end
      rrts_pkg::S_SCAN: begin
        if (sts.scan_done) begin
          state_next = rrts_pkg::S_DECIDE;
        end
      end
      rrts_pkg::S_DECIDE: begin
        state_next = sts.need_switch ? rrts_pkg::S_SWITCH : rrts_pkg::S_DONE;
      end
      rrts_pkg::S_SWITCH:  state_next = rrts_pkg::S_DONE;
      rrts_pkg::S_DONE: begin
        if (out_free) begin
          state_next = rrts_pkg::S_IDLE;
        end
      end
      default: state_next = rrts_pkg::S_IDLE;
    endcase
    // The request type is only known after the item is latched, so an
    // entry write is steered to S_ENTRY from S_CUR_RD, not from S_IDLE.
    if (state == rrts_pkg::S_CUR_RD && sts.req_type == rrts_pkg::REQ_WRITE) begin
      state_next = rrts_pkg::S_ENTRY;
    end
  end

  always_comb begin
    cmd = '0;
    req_stall = 1'b1;
    case (state)
      rrts_pkg::S_IDLE: begin
        req_stall     = 1'b0;
        cmd.latch_req = req_valid;
      end
      rrts_pkg::S_ENTRY:   cmd.entry_wr = 1'b1;
      rrts_pkg::S_CUR_RD:  cmd.cur_rd   = (sts.req_type != rrts_pkg::REQ_WRITE);
      rrts_pkg::S_CUR_CAP: begin
        cmd.cur_cap    = 1'b1;
        cmd.scan_start = !early_done;
      end
      rrts_pkg::S_SCAN:    cmd.scan_run  = 1'b1;
      rrts_pkg::S_DECIDE:  cmd.decide    = 1'b1;
      rrts_pkg::S_SWITCH:  cmd.switch_en = 1'b1;
      rrts_pkg::S_DONE:    cmd.rsp_load  = out_free;
      default: ;
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (cmd.rsp_load) begin
      rsp_valid_next = 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rrts_pkg::S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

`default_nettype wire

[hdl/rrts_dpath.sv]
// ----------------------------------------------------------------------------
// Scheduler datapath
// Entry table access through the RAM, sleeper countdown with round-robin
// pick, running entry, tick count and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_dpath #(
  parameter int NUM_PROCS = rrts_pkg::NUM_PROCS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire rrts_pkg::cmd_t               cmd,
  output rrts_pkg::sts_t                    sts,
  input  wire rrts_pkg::req_item_t          req_item,
  input  wire logic [7:0]                   time_slice,
  output rrts_pkg::rsp_item_t               rsp_item,
  output logic                              ram_wr_en,
  output logic [$clog2(NUM_PROCS)-1:0]      ram_wr_addr,
  output rrts_pkg::entry_t                  ram_wr_data,
  output logic                              ram_rd_en,
  output logic [$clog2(NUM_PROCS)-1:0]      ram_rd_addr,
  input  wire rrts_pkg::entry_t             ram_rd_data
);

  localparam int IW = $clog2(NUM_PROCS);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_PROCS - 1);

  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  rrts_pkg::req_item_t req_q;
  logic [IW-1:0]       running_entry;
  logic [31:0]         tick_counter;
  rrts_pkg::entry_t    cur_entry;
  logic [IW-1:0]       scan_idx;
  logic [IW-1:0]       rd_left;
  logic                pipe_v;
  logic [IW-1:0]       wb_idx;
  logic                found;
  logic [IW-1:0]       found_idx;
  rrts_pkg::entry_t    found_entry;
  rrts_pkg::entry_t    zero_entry;
  logic [IW-1:0]       pick_idx;
  rrts_pkg::entry_t    pick_entry;
  logic                switched_q;
  logic                status_q;
  logic [NUM_PROCS-1:0] valid;
  logic                rd_valid_q;
  logic                rd_is0_q;

  rrts_pkg::entry_t    rdata_eff;
  rrts_pkg::entry_t    cap_e;
  rrts_pkg::entry_t    scan_e;
  logic                scan_elig;
  rrts_pkg::entry_t    dem_e;
  logic                keep;
  logic                cur_elig;
  logic [IW-1:0]       pick;
  logic [31:0]         target_ext;
  logic                target_ok;
  logic [IW-1:0]       target_idx;
  logic [31:0]         run_ext;
  logic                scan_rd;

  assign target_ext = 32'(req_q.target_pid);
  assign target_ok  = target_ext < 32'(NUM_PROCS);
  assign target_idx = target_ext[IW-1:0];
  assign run_ext    = 32'(running_entry);

  // Entries never written read as their reset contents.
  always_comb begin
    if (rd_valid_q) begin
      rdata_eff = ram_rd_data;
    end else if (rd_is0_q) begin
      rdata_eff = rrts_pkg::ENTRY_IDLE0;
    end else begin
      rdata_eff = rrts_pkg::ENTRY_DEAD;
    end
  end

  // Current entry as prepared by a sleep or yield request.
  always_comb begin
    cap_e = rdata_eff;
    case (req_q.req_type)
      rrts_pkg::REQ_SLEEP: begin
        cap_e.pstate    = rrts_pkg::PS_SLEEPING;
        cap_e.sleep_cnt = req_q.sleep_ticks;
      end
      rrts_pkg::REQ_YIELD: begin
        cap_e.slice_cnt = time_slice;
      end
      default: ;
    endcase
  end

  // Sleepers count down to runnable; one at zero wraps and keeps sleeping.
  always_comb begin
    scan_e = rdata_eff;
    if (rdata_eff.pstate == rrts_pkg::PS_SLEEPING) begin
      scan_e.sleep_cnt = rdata_eff.sleep_cnt - 16'd1;
      if (scan_e.sleep_cnt == 16'd0) begin
        scan_e.pstate = rrts_pkg::PS_RUNNABLE;
      end
    end
    scan_elig = (scan_e.pstate == rrts_pkg::PS_RUNNABLE) && !scan_e.blocked;
  end

  always_comb begin
    keep = (cur_entry.pstate == rrts_pkg::PS_RUNNING) &&
           (cur_entry.slice_cnt < time_slice) && !cur_entry.blocked;
    dem_e = cur_entry;
    if (keep) begin
      dem_e.slice_cnt = cur_entry.slice_cnt + 8'd1;
    end else if (cur_entry.pstate == rrts_pkg::PS_RUNNING) begin
      dem_e.pstate    = rrts_pkg::PS_RUNNABLE;
      dem_e.slice_cnt = 8'd0;
    end
    cur_elig = (dem_e.pstate == rrts_pkg::PS_RUNNABLE) && !dem_e.blocked;
    if (keep) begin
      pick = running_entry;
    end else if (found) begin
      pick = found_idx;
    end else if (cur_elig) begin
      pick = running_entry;
    end else begin
      pick = '0;
    end
  end

  assign scan_rd     = cmd.scan_run && (rd_left != '0);
  assign ram_rd_en   = cmd.cur_rd || scan_rd;
  assign ram_rd_addr = cmd.cur_rd ? running_entry : scan_idx;

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = running_entry;
    ram_wr_data = dem_e;
    if (cmd.entry_wr) begin
      ram_wr_en   = target_ok;
      ram_wr_addr = target_idx;
      ram_wr_data = '{pstate: req_q.new_state, blocked: req_q.new_blocked,
                      sleep_cnt: req_q.sleep_ticks, slice_cnt: 8'd0};
    end else if (cmd.scan_run && pipe_v) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = wb_idx;
      ram_wr_data = scan_e;
    end else if (cmd.decide) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = running_entry;
      ram_wr_data = dem_e;
    end else if (cmd.switch_en) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = pick_idx;
      ram_wr_data = '{pstate: rrts_pkg::PS_RUNNING, blocked: pick_entry.blocked,
                      sleep_cnt: pick_entry.sleep_cnt, slice_cnt: 8'd1};
    end
  end

  assign sts.req_type    = req_q.req_type;
  assign sts.ticks_zero  = (req_q.sleep_ticks == 16'd0);
  assign sts.cur_ok      = (rdata_eff.pstate == rrts_pkg::PS_RUNNING) && !rdata_eff.blocked;
  assign sts.scan_done   = (rd_left == '0) && !pipe_v;
  assign sts.need_switch = (pick != running_entry);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_entry <= '0;
      tick_counter  <= '0;
      valid         <= '0;
      pipe_v        <= 1'b0;
      rd_left       <= '0;
      found         <= 1'b0;
    end else begin
      if (ram_wr_en) begin
        valid[ram_wr_addr] <= 1'b1;
      end
      if (cmd.scan_start) begin
        tick_counter <= tick_counter + 32'd1;
        rd_left      <= LAST_IDX;
        found        <= 1'b0;
      end else if (scan_rd) begin
        rd_left <= rd_left - 1'b1;
      end
      pipe_v <= scan_rd;
      if (cmd.scan_run && pipe_v && !found && (wb_idx != '0) && scan_elig) begin
        found <= 1'b1;
      end
      if (cmd.switch_en) begin
        running_entry <= pick_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_q      <= req_item;
      switched_q <= 1'b0;
      status_q   <= 1'b0;
    end
    if (ram_rd_en) begin
      rd_valid_q <= valid[ram_rd_addr];
      rd_is0_q   <= (ram_rd_addr == '0);
    end
    if (cmd.cur_cap) begin
      cur_entry <= cap_e;
      status_q  <= (req_q.req_type == rrts_pkg::REQ_YIELD) && !sts.cur_ok;
    end
    if (cmd.scan_start) begin
      scan_idx <= next_idx(running_entry);
    end else if (scan_rd) begin
      scan_idx <= next_idx(scan_idx);
    end
    wb_idx <= scan_idx;
    if (cmd.scan_run && pipe_v) begin
      if (!found && (wb_idx != '0) && scan_elig) begin
        found_idx   <= wb_idx;
        found_entry <= scan_e;
      end
      if (wb_idx == '0) begin
        zero_entry <= scan_e;
      end
    end
    if (cmd.decide) begin
      pick_idx   <= pick;
      pick_entry <= found ? found_entry : zero_entry;
    end
    if (cmd.switch_en) begin
      switched_q <= 1'b1;
    end
    if (cmd.rsp_load) begin
      rsp_item.running_pid <= run_ext[3:0];
      rsp_item.switched    <= switched_q;
      rsp_item.tick_total  <= tick_counter;
      rsp_item.status      <= status_q;
    end
  end

endmodule

`default_nettype wire

[hdl/round_robin_tick_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// Round-robin tick scheduler
// Time-slice scheduler over a table of process entries held in a RAM.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Payload
//   req       in         req_valid / req_stall  req_item (rrts_pkg::req_item_t)
//   rsp       out        rsp_valid / rsp_stall  rsp_item (rrts_pkg::rsp_item_t)
//   config    in         APB, pready always 1   time_slice at paddr 0
//
// An entry write passes through S_CUR_RD, S_ENTRY and S_DONE. A tick, sleep or
// yield reads and captures the current entry, scans the sleepers, decides and,
// for a switch, adds S_SWITCH; the sleeper scan reads one entry per cycle through
// the single RAM read port. Refused yields and zero-length sleeps skip the scan.
// Reset is synchronous; RAM contents are tracked by per-entry valid bits, so
// no clearing pass is needed. A stalled result does not block acceptance of
// the next item; that item waits only at its own result handoff.
//
`default_nettype none

module round_robin_tick_scheduler_unit #(
  parameter int NUM_PROCS = rrts_pkg::NUM_PROCS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rrts_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  input  wire logic                        req_valid,
  output logic                             req_stall,
  input  wire rrts_pkg::req_item_t         req_item,
  output logic                             rsp_valid,
  input  wire logic                        rsp_stall,
  output rrts_pkg::rsp_item_t              rsp_item
);

  localparam int IW = $clog2(NUM_PROCS);

  logic [7:0]          time_slice;
  logic                cfg_wr;
  rrts_pkg::cmd_t      cmd;
  rrts_pkg::sts_t      sts;
  logic                ram_wr_en;
  logic [IW-1:0]       ram_wr_addr;
  rrts_pkg::entry_t    ram_wr_data;
  logic                ram_rd_en;
  logic [IW-1:0]       ram_rd_addr;
  rrts_pkg::entry_t    ram_rd_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == rrts_pkg::REG_TIME_SLICE);
  assign prdata = (paddr[2] == rrts_pkg::REG_TIME_SLICE) ? 32'(time_slice) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_slice <= rrts_pkg::TIME_SLICE_RST;
    end else if (cfg_wr) begin
      time_slice <= pwdata[7:0];
    end
  end

  rrts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rrts_dpath #(
    .NUM_PROCS (NUM_PROCS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .req_item    (req_item),
    .time_slice  (time_slice),
    .rsp_item    (rsp_item),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  rrts_ram #(
    .WIDTH ($bits(rrts_pkg::entry_t)),
    .DEPTH (NUM_PROCS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule

`default_nettype wire

[hdl/rrts_checker.sv]
// ----------------------------------------------------------------------------
// Scheduler port checker
// Concurrent checks on the scheduler ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "round_robin_tick_scheduler_unit_macros.svh"

module rrts_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         psel,
  input wire logic                         penable,
  input wire logic                         pwrite,
  input wire logic [rrts_pkg::PADDR_W-1:0] paddr,
  input wire logic [31:0]                  pwdata,
  input wire logic [31:0]                  prdata,
  input wire logic                         pready,
  input wire logic                         req_valid,
  input wire logic                         req_stall,
  input wire logic                         rsp_valid,
  input wire logic                         rsp_stall,
  input wire rrts_pkg::rsp_item_t          rsp_item
);

  logic slice_addr;
  logic slice_wr;
  logic rsp_held;

  assign slice_addr = (paddr[2] == rrts_pkg::REG_TIME_SLICE);
  assign slice_wr   = psel && penable && pwrite && pready && slice_addr;
  assign rsp_held   = rsp_valid && rsp_stall;

  // A held result keeps its contents until taken.
  `RRTS_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_held, rsp_valid && $stable(rsp_item))

  // Items are worked one at a time, so acceptance closes the input.
  `RRTS_ASSERT_NEXT(a_one_at_a_time, clk, rst, req_valid && !req_stall, req_stall)

  // A refused yield never changes the running entry.
  `RRTS_ASSERT_SAME(a_refuse_no_switch, clk, rst, rsp_valid && rsp_item.status, !rsp_item.switched)

  // The slice register reads back what was written.
  `RRTS_ASSERT_NEXT(a_cfg_readback, clk, rst, slice_wr, !slice_addr || (prdata[7:0] == $past(pwdata[7:0])))

endmodule

bind round_robin_tick_scheduler_unit rrts_checker u_rrts_checker (
  .clk       (clk),
  .rst       (rst),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata),
  .pready    (pready),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp_item  (rsp_item)
);

`default_nettype wire
